>>> design/lpid_pkg.sv
package lpid_pkg;

    // Field widths of the channels and the configuration port.
    localparam int LIGHT_W    = 10;
    localparam int GAIN_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int TURN_W     = 16;
    localparam int DRIVE_W    = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal widths: error, integral increment and Q16.16 accumulator.
    localparam int ERR_W = 12;
    localparam int INC_W = 20;
    localparam int ACC_W = 32;

    // Loop mode codes. Any other non-zero code behaves as hold.
    localparam logic [MODE_W-1:0] LOOP_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] LOOP_LINE = 2'd1;
    localparam logic [MODE_W-1:0] LOOP_HOLD = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_LIGHT_TARGET = 3'd3,
        CFG_LOOP_MODE    = 3'd4,
        CFG_MANUAL_TURN  = 3'd5,
        CFG_TAIL_GAIN    = 3'd6,
        CFG_TAIL_TARGET  = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST    = 16'sd256;
    localparam logic signed [GAIN_W-1:0] TAIL_GAIN_RST    = 16'sd205;
    localparam logic [LIGHT_W-1:0]       LIGHT_TARGET_RST = 10'd600;

    // The increment is mag * 131.072 rounded: mag * 131 plus
    // (mag * 72 + 500) / 1000, the latter by a reciprocal multiply that is
    // exact for dividends below 2^18.
    localparam logic [18:0] INC_WHOLE  = 19'd131;
    localparam logic [17:0] INC_FRAC   = 18'd72;
    localparam logic [17:0] INC_ROUND  = 18'd500;
    localparam logic [18:0] INC_RECIP  = 19'd268436;

    // Tail duty limit in percent.
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd100;

endpackage

>>> design/lpid_if.sv
// Input channel: one light sample and one tail encoder count per transaction.
interface lpid_in_if;
    logic                                      valid;
    logic                                      ready;
    logic        [lpid_pkg::LIGHT_W-1:0]       light_sample;
    logic signed [lpid_pkg::COUNT_W-1:0]       tail_count;

    modport source (output valid, light_sample, tail_count, input ready);
    modport sink   (input valid, light_sample, tail_count, output ready);
endinterface

// Output channel: steering command, tail duty and saturation flag.
interface lpid_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [lpid_pkg::TURN_W-1:0]        turn_out;
    logic signed [lpid_pkg::DRIVE_W-1:0]       tail_drive;
    logic                                      turn_saturated;

    modport source (output valid, turn_out, tail_drive, turn_saturated, input ready);
    modport sink   (input valid, turn_out, tail_drive, turn_saturated, output ready);
endinterface

>>> design/line_pid_and_tail_p_controller.sv
// Line-following PID steering controller with a proportional tail loop.
//
// Input channel i_in carries one light sample and one tail encoder count
// per transaction; output channel o_out returns exactly one result for each
// input: the steering command, the tail duty in percent and a flag that is
// set when the integral or the turn saturated. Both channels use valid and
// ready; a transaction completes when both are high at a rising edge.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data, one register per cycle; the user must see that they are
// written only while the block is empty, as the block does not enforce it.
//
// A new input is accepted every cycle while the receiver takes results;
// the error recurrence closes at the intake register and the Q16.16
// integral recurrence closes in the third stage. The remaining stages hold
// the gain multiplies and the final sum. When the receiver stalls, the five
// stages fill up and i_in.ready falls once no stage can move. Reset clears
// the pipeline, the last error and the integral, and loads the register
// reset values.
module line_pid_and_tail_p_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lpid_in_if.sink                             i_in,
    lpid_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [lpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic signed [lpid_pkg::GAIN_W-1:0]  r_prop_gain;
    logic signed [lpid_pkg::GAIN_W-1:0]  r_integ_gain;
    logic signed [lpid_pkg::GAIN_W-1:0]  r_deriv_gain;
    logic        [lpid_pkg::LIGHT_W-1:0] r_light_target;
    logic        [lpid_pkg::MODE_W-1:0]  r_loop_mode;
    logic signed [lpid_pkg::TURN_W-1:0]  r_manual_turn;
    logic signed [lpid_pkg::GAIN_W-1:0]  r_tail_gain;
    logic signed [lpid_pkg::COUNT_W-1:0] r_tail_target;

    // Controller state.
    logic signed [lpid_pkg::ERR_W-1:0]   r_last_err;
    logic signed [lpid_pkg::ACC_W-1:0]   r_acc;

    // Stage valids and per-stage ready.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage 1: errors and tail error.
    logic signed [lpid_pkg::ERR_W-1:0]   r1_e, r1_pe, n_e;
    logic signed [lpid_pkg::COUNT_W:0]   r1_terr, n_terr;
    logic                                r1_off;

    // Stage 2: increment and gain products.
    logic signed [lpid_pkg::INC_W-1:0]   r2_inc, n_inc;
    logic signed [27:0]                  r2_pprod;
    logic signed [28:0]                  r2_dprod;
    logic signed [32:0]                  r2_tprod;
    logic signed [lpid_pkg::ERR_W:0]     diff;
    logic                                r2_off;

    // Stage 3: accumulator update and tail clamp.
    logic signed [lpid_pkg::ACC_W:0]     acc_sum;
    logic signed [lpid_pkg::ACC_W-1:0]   n_acc;
    logic                                acc_hit;
    logic signed [32:0]                  tail_adj;
    logic signed [24:0]                  tail_q;
    logic signed [lpid_pkg::DRIVE_W-1:0] n_drive;
    logic signed [27:0]                  r3_pprod;
    logic signed [28:0]                  r3_dprod;
    logic signed [lpid_pkg::DRIVE_W-1:0] r3_drive;
    logic                                r3_sat;
    logic                                r3_off;

    // Stage 4: integral product.
    logic signed [47:0]                  r4_iprod;
    logic signed [27:0]                  r4_pprod;
    logic signed [28:0]                  r4_dprod;
    logic signed [lpid_pkg::DRIVE_W-1:0] r4_drive;
    logic                                r4_sat;
    logic                                r4_off;

    // Stage 5: output register.
    logic signed [49:0]                  turn_sum;
    logic signed [49:0]                  turn_adj;
    logic signed [25:0]                  turn_q;
    logic signed [lpid_pkg::TURN_W-1:0]  n_turn;
    logic                                turn_hit;
    logic signed [lpid_pkg::TURN_W-1:0]  r5_turn;
    logic signed [lpid_pkg::DRIVE_W-1:0] r5_drive;
    logic                                r5_sat;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= lpid_pkg::PROP_GAIN_RST;
            r_integ_gain   <= '0;
            r_deriv_gain   <= '0;
            r_light_target <= lpid_pkg::LIGHT_TARGET_RST;
            r_loop_mode    <= lpid_pkg::LOOP_OFF;
            r_manual_turn  <= '0;
            r_tail_gain    <= lpid_pkg::TAIL_GAIN_RST;
            r_tail_target  <= '0;
        end else if (i_cfg_we) begin
            unique case (lpid_pkg::t_cfg_idx'(i_cfg_idx))
                lpid_pkg::CFG_PROP_GAIN:    r_prop_gain    <= $signed(i_cfg_data);
                lpid_pkg::CFG_INTEG_GAIN:   r_integ_gain   <= $signed(i_cfg_data);
                lpid_pkg::CFG_DERIV_GAIN:   r_deriv_gain   <= $signed(i_cfg_data);
                lpid_pkg::CFG_LIGHT_TARGET: r_light_target <= i_cfg_data[lpid_pkg::LIGHT_W-1:0];
                lpid_pkg::CFG_LOOP_MODE:    r_loop_mode    <= i_cfg_data[lpid_pkg::MODE_W-1:0];
                lpid_pkg::CFG_MANUAL_TURN:  r_manual_turn  <= $signed(i_cfg_data);
                lpid_pkg::CFG_TAIL_GAIN:    r_tail_gain    <= $signed(i_cfg_data);
                lpid_pkg::CFG_TAIL_TARGET:  r_tail_target  <= $signed(i_cfg_data);
                default:                    r_prop_gain    <= r_prop_gain;
            endcase
        end
    end

    // Each stage moves when it is empty or the stage after it moves.
    assign rdy5        = !r_v5 || o_out.ready;
    assign rdy4        = !r_v4 || rdy5;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_in.ready  = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Intake: line mode follows the sample, hold mode keeps the last error.
    always_comb begin
        if (r_loop_mode == lpid_pkg::LOOP_LINE) begin
            n_e = $signed({2'b00, i_in.light_sample}) - $signed({2'b00, r_light_target});
        end else begin
            n_e = r_last_err;
        end
        n_terr = {r_tail_target[lpid_pkg::COUNT_W-1], r_tail_target}
               - {i_in.tail_count[lpid_pkg::COUNT_W-1], i_in.tail_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
        end else if (rdy1 && i_in.valid && r_loop_mode != lpid_pkg::LOOP_OFF) begin
            r_last_err <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r1_e    <= n_e;
            r1_pe   <= r_last_err;
            r1_terr <= n_terr;
            r1_off  <= (r_loop_mode == lpid_pkg::LOOP_OFF);
        end
    end

    // Stage 2: integral increment and the proportional, derivative, tail products.
    lpid_incr u_incr (
        .i_err      (r1_e),
        .i_prev_err (r1_pe),
        .o_inc      (n_inc)
    );

    assign diff = {r1_e[lpid_pkg::ERR_W-1], r1_e} - {r1_pe[lpid_pkg::ERR_W-1], r1_pe};

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r2_inc   <= n_inc;
            r2_pprod <= r_prop_gain * r1_e;
            r2_dprod <= r_deriv_gain * diff;
            r2_tprod <= r_tail_gain * r1_terr;
            r2_off   <= r1_off;
        end
    end

    // Stage 3: saturating accumulator; tail product divided by 256 toward
    // zero and clamped to the duty range.
    always_comb begin
        acc_sum = {r_acc[lpid_pkg::ACC_W-1], r_acc}
                + {{(lpid_pkg::ACC_W + 1 - lpid_pkg::INC_W){r2_inc[lpid_pkg::INC_W-1]}},
                   r2_inc};
        acc_hit = (acc_sum[lpid_pkg::ACC_W] != acc_sum[lpid_pkg::ACC_W-1]);
        if (acc_hit) begin
            n_acc = acc_sum[lpid_pkg::ACC_W] ? {1'b1, {(lpid_pkg::ACC_W-1){1'b0}}}
                                             : {1'b0, {(lpid_pkg::ACC_W-1){1'b1}}};
        end else begin
            n_acc = acc_sum[lpid_pkg::ACC_W-1:0];
        end

        tail_adj = r2_tprod + (r2_tprod[32] ? 33'sd255 : 33'sd0);
        tail_q   = tail_adj[32:8];
        priority if (tail_q > 25'(lpid_pkg::DRIVE_MAX)) begin
            n_drive = lpid_pkg::DRIVE_MAX;
        end else if (tail_q < 25'(lpid_pkg::DRIVE_MIN)) begin
            n_drive = lpid_pkg::DRIVE_MIN;
        end else begin
            n_drive = tail_q[lpid_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (rdy3 && r_v2 && !r2_off) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r3_pprod <= r2_pprod;
            r3_dprod <= r2_dprod;
            r3_drive <= n_drive;
            r3_sat   <= acc_hit && !r2_off;
            r3_off   <= r2_off;
        end
    end

    // Stage 4: integral term. The accumulator still holds this item's value.
    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r4_iprod <= r_integ_gain * r_acc;
            r4_pprod <= r3_pprod;
            r4_dprod <= r3_dprod;
            r4_drive <= r3_drive;
            r4_sat   <= r3_sat;
            r4_off   <= r3_off;
        end
    end

    // Stage 5: Q26.24 sum, divided by 2^24 toward zero, saturated to 16 bits.
    always_comb begin
        turn_sum = {{6{r4_pprod[27]}}, r4_pprod, 16'd0}
                 + {{2{r4_iprod[47]}}, r4_iprod}
                 + {{5{r4_dprod[28]}}, r4_dprod, 16'd0};
        turn_adj = turn_sum + (turn_sum[49] ? 50'sd16777215 : 50'sd0);
        turn_q   = turn_adj[49:24];
        turn_hit = 1'b1;
        priority if (turn_q > 26'sd32767) begin
            n_turn = 16'sd32767;
        end else if (turn_q < -26'sd32768) begin
            n_turn = -16'sd32768;
        end else begin
            n_turn   = turn_q[lpid_pkg::TURN_W-1:0];
            turn_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            r5_turn  <= r4_off ? r_manual_turn : n_turn;
            r5_drive <= r4_drive;
            r5_sat   <= !r4_off && (r4_sat || turn_hit);
        end
    end

    assign o_out.valid          = r_v5;
    assign o_out.turn_out       = r5_turn;
    assign o_out.tail_drive     = r5_drive;
    assign o_out.turn_saturated = r5_sat;

    // The tail duty never leaves its percent range.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r5_drive <= lpid_pkg::DRIVE_MAX && r5_drive >= lpid_pkg::DRIVE_MIN))
        else $error("tail duty out of range");

    // Outside line mode the error repeats, so the derivative input is zero.
    a_hold_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r1_off && r_loop_mode != lpid_pkg::LOOP_LINE) |-> (r1_e == r1_pe))
        else $error("hold mode error changed");

    // In off mode neither the integral nor the last error moves.
    a_off_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loop_mode == lpid_pkg::LOOP_OFF && !i_cfg_we)
            |=> ($stable(r_acc) && $stable(r_last_err)))
        else $error("controller state changed in off mode");

endmodule

>>> design/lpid_incr.sv
// Trapezoidal integral increment: (e + e_prev) * 131.072 in Q16.16,
// rounded to nearest with ties away from zero.
module lpid_incr (
    input  logic signed [lpid_pkg::ERR_W-1:0] i_err,
    input  logic signed [lpid_pkg::ERR_W-1:0] i_prev_err,
    output logic signed [lpid_pkg::INC_W-1:0] o_inc
);

    logic signed [lpid_pkg::ERR_W:0] sum_err;
    logic        [lpid_pkg::ERR_W:0] abs_err;
    logic        [10:0]              mag;
    logic        [17:0]              frac_num;
    logic        [36:0]              frac_prod;
    logic        [8:0]               frac_q;
    logic        [18:0]              inc_mag;

    // Both errors stay within +/-1023, so the magnitude fits in 11 bits.
    assign sum_err = {i_err[lpid_pkg::ERR_W-1], i_err}
                   + {i_prev_err[lpid_pkg::ERR_W-1], i_prev_err};
    assign abs_err = sum_err[lpid_pkg::ERR_W] ? (~sum_err + 1'b1) : sum_err;
    assign mag     = abs_err[10:0];

    // Fractional part of the scale factor, divided by 1000 via reciprocal.
    assign frac_num  = {7'd0, mag} * lpid_pkg::INC_FRAC + lpid_pkg::INC_ROUND;
    assign frac_prod = {19'd0, frac_num} * {18'd0, lpid_pkg::INC_RECIP};
    assign frac_q    = frac_prod[36:28];

    // Whole part plus fraction, then the sign of the error sum.
    assign inc_mag = {8'd0, mag} * lpid_pkg::INC_WHOLE + {10'd0, frac_q};
    assign o_inc   = sum_err[lpid_pkg::ERR_W] ? -$signed({1'b0, inc_mag})
                                              : $signed({1'b0, inc_mag});

endmodule
